>>> rtl/lab_pkg.sv
// Shared types and constants for the look-at basis pipeline.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package lab_pkg;

  localparam int OUT_FRAC_BITS = 14;
  // result magnitude bits searched, one per step
  localparam int QB     = 16;
  localparam int NSTEP  = QB;
  // width of the square-length divisor and of the squared numerator
  localparam int SW     = 63;
  localparam int A2W    = 64;
  localparam int SH     = 2 * OUT_FRAC_BITS + 2;
  localparam int RBASE  = ((A2W + SH) > (SW + 2 * QB + 2)) ? (A2W + SH) : (SW + 2 * QB + 2);
  localparam int RW     = RBASE + 3;
  localparam int TW     = SW + QB + 3;
  localparam int NLANE  = 8;
  localparam int FRONT_LAT = 4;
  localparam int RATIO_LAT = NSTEP + 2;
  localparam int LAT    = FRONT_LAT + RATIO_LAT;
  localparam logic [QB:0] MAG_CAP = (QB + 1)'(32768);

  // lane order of the eight ratio units
  localparam int L_SIDE_X = 0;
  localparam int L_SIDE_Z = 1;
  localparam int L_UP_X   = 2;
  localparam int L_UP_Y   = 3;
  localparam int L_UP_Z   = 4;
  localparam int L_BACK_X = 5;
  localparam int L_BACK_Y = 6;
  localparam int L_BACK_Z = 7;

  typedef struct packed {
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic signed [15:0] cam_z;
  } lab_in_t;

  typedef struct packed {
    logic signed [15:0] side_x;
    logic signed [15:0] side_y;
    logic signed [15:0] side_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [15:0] back_x;
    logic signed [15:0] back_y;
    logic signed [15:0] back_z;
    logic               degenerate;
  } lab_out_t;

  // one ratio problem: round(sqrt(a2) * 2^FRAC / sqrt(s)) with a sign
  typedef struct packed {
    logic [SW-1:0]  s;
    logic [A2W-1:0] a2;
    logic           neg;
  } lab_lane_t;

endpackage

>>> rtl/lab_front.sv
// Front end: squares, cross products, lengths and squared numerators.
// Four register stages; depends on lab_pkg.
`timescale 1ns / 1ps
module lab_front (
  input  logic                clk,
  input  logic                en,
  input  lab_pkg::lab_in_t    in_data,
  output lab_pkg::lab_lane_t  lanes_o [lab_pkg::NLANE]
);
  import lab_pkg::*;

  lab_in_t f1_r;

  logic [31:0]        xx_r, yy_r, zz_r;
  logic signed [31:0] pxy_r, pyz_r;
  logic [NLANE-1:0]   neg2_r;

  logic [31:0]        h2_r, l2_r, xx3_r, yy3_r, zz3_r;
  logic [30:0]        apxy_r, apyz_r;
  logic [NLANE-1:0]   neg3_r;

  logic signed [31:0] pxy_nxt, pyz_nxt;
  logic [NLANE-1:0]   neg_nxt;
  logic [63:0]        hl_nxt, h2sq_nxt;
  logic [61:0]        pxysq_nxt, pyzsq_nxt;

  always_comb begin
    pxy_nxt = f1_r.cam_x * f1_r.cam_y;
    pyz_nxt = f1_r.cam_y * f1_r.cam_z;
    neg_nxt = '0;
    neg_nxt[L_SIDE_X] = f1_r.cam_z[15];
    neg_nxt[L_SIDE_Z] = !f1_r.cam_x[15] && (f1_r.cam_x != 16'sd0);
    neg_nxt[L_UP_X]   = !pxy_nxt[31] && (pxy_nxt != 32'sd0);
    neg_nxt[L_UP_Y]   = 1'b0;
    neg_nxt[L_UP_Z]   = !pyz_nxt[31] && (pyz_nxt != 32'sd0);
    neg_nxt[L_BACK_X] = f1_r.cam_x[15];
    neg_nxt[L_BACK_Y] = f1_r.cam_y[15];
    neg_nxt[L_BACK_Z] = f1_r.cam_z[15];
    hl_nxt    = 64'(h2_r) * 64'(l2_r);
    h2sq_nxt  = 64'(h2_r) * 64'(h2_r);
    pxysq_nxt = 62'(apxy_r) * 62'(apxy_r);
    pyzsq_nxt = 62'(apyz_r) * 62'(apyz_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r   <= in_data;
      xx_r   <= 32'(f1_r.cam_x) * 32'(f1_r.cam_x);
      yy_r   <= 32'(f1_r.cam_y) * 32'(f1_r.cam_y);
      zz_r   <= 32'(f1_r.cam_z) * 32'(f1_r.cam_z);
      pxy_r  <= pxy_nxt;
      pyz_r  <= pyz_nxt;
      neg2_r <= neg_nxt;

      h2_r   <= xx_r + zz_r;
      l2_r   <= xx_r + zz_r + yy_r;
      xx3_r  <= xx_r;
      yy3_r  <= yy_r;
      zz3_r  <= zz_r;
      apxy_r <= 31'(pxy_r[31] ? -pxy_r : pxy_r);
      apyz_r <= 31'(pyz_r[31] ? -pyz_r : pyz_r);
      neg3_r <= neg2_r;

      lanes_o[L_SIDE_X] <= '{s: SW'(h2_r), a2: A2W'(zz3_r), neg: neg3_r[L_SIDE_X]};
      lanes_o[L_SIDE_Z] <= '{s: SW'(h2_r), a2: A2W'(xx3_r), neg: neg3_r[L_SIDE_Z]};
      lanes_o[L_UP_X]   <= '{s: hl_nxt[SW-1:0], a2: A2W'(pxysq_nxt), neg: neg3_r[L_UP_X]};
      lanes_o[L_UP_Y]   <= '{s: hl_nxt[SW-1:0], a2: h2sq_nxt, neg: neg3_r[L_UP_Y]};
      lanes_o[L_UP_Z]   <= '{s: hl_nxt[SW-1:0], a2: A2W'(pyzsq_nxt), neg: neg3_r[L_UP_Z]};
      lanes_o[L_BACK_X] <= '{s: SW'(l2_r), a2: A2W'(xx3_r), neg: neg3_r[L_BACK_X]};
      lanes_o[L_BACK_Y] <= '{s: SW'(l2_r), a2: A2W'(yy3_r), neg: neg3_r[L_BACK_Y]};
      lanes_o[L_BACK_Z] <= '{s: SW'(l2_r), a2: A2W'(zz3_r), neg: neg3_r[L_BACK_Z]};
    end
  end

endmodule

>>> rtl/lab_ratio.sv
// One rounded ratio lane: bit-per-stage search of round(a * 2^FRAC / sqrt(s)).
// Residual and cross term are updated by shifts and adds only; depends on lab_pkg.
`timescale 1ns / 1ps
module lab_ratio (
  input  logic               clk,
  input  logic               en,
  input  lab_pkg::lab_lane_t lane_i,
  output logic [15:0]        field_o
);
  import lab_pkg::*;

  // residual = a^2 * 2^SH - (2q-1)^2 * s, cross = (2q-1) * s
  logic signed [RW-1:0] r_r [NSTEP+1];
  logic signed [TW-1:0] t_r [NSTEP+1];
  logic [SW-1:0]        s_r [NSTEP+1];
  logic [QB-1:0]        q_r [NSTEP+1];
  logic                 neg_r [NSTEP+1];

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= $signed(RW'(lane_i.a2) << SH) - $signed(RW'(lane_i.s));
      t_r[0]   <= -$signed(TW'(lane_i.s));
      s_r[0]   <= lane_i.s;
      q_r[0]   <= '0;
      neg_r[0] <= lane_i.neg;
    end
  end

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    localparam int K = NSTEP - 1 - g;
    logic signed [RW-1:0] inc, cand;
    logic                 take;

    always_comb begin
      inc  = (RW'(t_r[g]) <<< (K + 2)) + $signed(RW'(s_r[g]) << (2 * K + 2));
      cand = r_r[g] - inc;
      take = !cand[RW-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[g+1]   <= take ? cand : r_r[g];
        t_r[g+1]   <= take ? t_r[g] + $signed(TW'(s_r[g]) << (K + 1)) : t_r[g];
        s_r[g+1]   <= s_r[g];
        q_r[g+1]   <= take ? (q_r[g] | (QB'(1) << K)) : q_r[g];
        neg_r[g+1] <= neg_r[g];
      end
    end
  end

  logic [QB:0]   mag;
  logic [15:0]   field_nxt;

  always_comb begin
    mag = ((QB + 1)'(q_r[NSTEP]) > MAG_CAP) ? MAG_CAP : (QB + 1)'(q_r[NSTEP]);
    if (neg_r[NSTEP]) begin
      field_nxt = 16'((QB + 1)'(0) - mag);
    end else if (mag > (QB + 1)'(32767)) begin
      field_nxt = 16'h7FFF;
    end else begin
      field_nxt = mag[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      field_o <= field_nxt;
    end
  end

endmodule

>>> rtl/look_at_basis.sv
// Look-at rotation basis: top level with handshake, valid pipeline and output mux.
// Instantiates lab_front and eight lab_ratio lanes; depends on lab_pkg.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries a camera position
//   (three signed Q8.8 values). Result channel out_valid / out_stall / out_data
//   carries the side, up and back vectors in signed Q1.14 plus a degenerate flag.
//   A transfer happens on a rising edge with valid high and stall low.
//   From input transfer to result the path runs through an input register,
//   three front stages (squares, sums, wide products), one setup stage,
//   sixteen search stages that each settle one result bit, and one output register.
//   One item per cycle is accepted while the receiver does not stall a valid
//   result; the sixteen-stage bit search per lane makes up most of the depth.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits; no result is presented until the first
//   item has passed through. On the y axis or at the origin the vectors
//   are zero and degenerate is set.
`timescale 1ns / 1ps
module look_at_basis (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lab_pkg::lab_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lab_pkg::lab_out_t  out_data
);
  import lab_pkg::*;

  logic            en;
  logic [LAT-1:0]  v_r;
  logic [LAT-1:0]  deg_r;
  lab_lane_t       lanes [NLANE];
  logic [15:0]     fields [NLANE];

  // hold everything while a result waits
  assign en        = !(v_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r <= {deg_r[LAT-2:0], (in_data.cam_x == 16'sd0) && (in_data.cam_z == 16'sd0)};
    end
  end

  lab_front u_front (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .lanes_o (lanes)
  );

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    lab_ratio u_ratio (
      .clk     (clk),
      .en      (en),
      .lane_i  (lanes[i]),
      .field_o (fields[i])
    );
  end

  logic dg;
  assign dg = deg_r[LAT-1];

  always_comb begin
    out_data.side_x     = dg ? 16'sd0 : $signed(fields[L_SIDE_X]);
    out_data.side_y     = 16'sd0;
    out_data.side_z     = dg ? 16'sd0 : $signed(fields[L_SIDE_Z]);
    out_data.up_x       = dg ? 16'sd0 : $signed(fields[L_UP_X]);
    out_data.up_y       = dg ? 16'sd0 : $signed(fields[L_UP_Y]);
    out_data.up_z       = dg ? 16'sd0 : $signed(fields[L_UP_Z]);
    out_data.back_x     = dg ? 16'sd0 : $signed(fields[L_BACK_X]);
    out_data.back_y     = dg ? 16'sd0 : $signed(fields[L_BACK_Y]);
    out_data.back_z     = dg ? 16'sd0 : $signed(fields[L_BACK_Z]);
    out_data.degenerate = dg;
  end

  a_deg_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.side_x == 16'sd0 && out_data.up_y == 16'sd0 && out_data.back_y == 16'sd0)
    else $error("degenerate result carries nonzero vector");

  a_up_y_pos : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.up_y[15])
    else $error("up_y negative");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(fields[L_BACK_X]) && $stable(deg_r))
    else $error("pipeline moved while held");

endmodule
